[rtl/core/point_in_triangle_ray_cast_assert.svh]
// Assertion macros for the point-in-triangle block.
// Used by point_in_triangle_ray_cast.sv; no other dependencies.
`ifndef POINT_IN_TRIANGLE_RAY_CAST_ASSERT_SVH
`define POINT_IN_TRIANGLE_RAY_CAST_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PITRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pitrc pipeline check failed");
// next-cycle implication
`define PITRC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pitrc pipeline check failed");
`else
`define PITRC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PITRC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/pitrc_pkg.sv]
// Shared types and constants of the point-in-triangle block.
// No dependencies; used by the edge unit and the top level.
`default_nettype none

package pitrc_pkg;

    localparam int FIELD_BITS = 32;
    localparam int NUM_REGS   = 6;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_L = 3'd0,
        REG_A_M = 3'd1,
        REG_B_L = 3'd2,
        REG_B_M = 3'd3,
        REG_C_L = 3'd4,
        REG_C_M = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] point_l;
        logic signed [FIELD_BITS-1:0] point_m;
    } t_point;

    typedef struct packed {
        logic inside_res;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [FIELD_BITS-1:0] value;
    } t_cfg_wr;

    // load enables of the three stages inside an edge unit
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

`default_nettype wire

[rtl/core/pitrc_chan_if.sv]
// Valid/ready channel carrying one payload word.
// The payload type is set by the parameter t_payload.
`default_nettype none

interface pitrc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/pitrc_edge.sv]
// Crossing test of one triangle edge against a +x ray, three register stages.
// Uses pitrc_pkg::t_stage_en for the stage load enables.
`default_nettype none

module pitrc_edge #(
    parameter int CB = 32
) (
    input  wire logic                 i_clk,
    input  wire pitrc_pkg::t_stage_en i_en,
    input  wire logic signed [CB-1:0] i_px,
    input  wire logic signed [CB-1:0] i_py,
    input  wire logic signed [CB-1:0] i_qx,
    input  wire logic signed [CB-1:0] i_qy,
    input  wire logic signed [CB-1:0] i_x,
    input  wire logic signed [CB-1:0] i_y,
    output logic                      o_cross
);

    localparam int D = CB + 1;      // difference width
    localparam int K = D / 2;       // low slice of a split operand
    localparam int H = D - K;       // high slice
    localparam int P = 2 * D;       // full product width

    // stage 1: span test and differences
    logic                r1_span;
    logic                r1_vert;
    logic                r1_dypos;
    logic signed [D-1:0] r1_opa [2];
    logic signed [D-1:0] r1_opb [2];

    logic w_gt_min, w_le_max, w_le_xmax;

    assign w_gt_min  = (i_y > i_py) || (i_y > i_qy);
    assign w_le_max  = (i_y <= i_py) || (i_y <= i_qy);
    assign w_le_xmax = (i_x <= i_px) || (i_x <= i_qx);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_span  <= w_gt_min && w_le_max && w_le_xmax;
            r1_vert  <= (i_px == i_qx);
            r1_dypos <= (i_qy > i_py);
            // product 0: (x - px) * (qy - py), product 1: (y - py) * (qx - px)
            r1_opa[0] <= {i_x[CB-1], i_x} - {i_px[CB-1], i_px};
            r1_opb[0] <= {i_qy[CB-1], i_qy} - {i_py[CB-1], i_py};
            r1_opa[1] <= {i_y[CB-1], i_y} - {i_py[CB-1], i_py};
            r1_opb[1] <= {i_qx[CB-1], i_qx} - {i_px[CB-1], i_px};
        end
    end

    // stage 2: four partial products per product
    logic                  r2_span;
    logic                  r2_vert;
    logic                  r2_dypos;
    logic [2*K-1:0]        r2_ll [2];
    logic signed [D:0]     r2_lh [2];
    logic signed [D:0]     r2_hl [2];
    logic signed [2*H-1:0] r2_hh [2];

    // stage 3: full products
    logic                  r3_span;
    logic                  r3_vert;
    logic                  r3_dypos;
    logic signed [P-1:0]   r3_prod [2];

    for (genvar j = 0; j < 2; j++) begin : g_prod
        logic [K-1:0]        w_alo, w_blo;
        logic signed [H-1:0] w_ahi, w_bhi;
        logic [P-1:0]        w_sum;

        assign w_alo = r1_opa[j][K-1:0];
        assign w_blo = r1_opb[j][K-1:0];
        assign w_ahi = $signed(r1_opa[j][D-1:K]);
        assign w_bhi = $signed(r1_opb[j][D-1:K]);

        always_ff @(posedge i_clk) begin
            if (i_en.s2) begin
                r2_ll[j] <= w_alo * w_blo;
                r2_lh[j] <= $signed({1'b0, w_alo}) * w_bhi;
                r2_hl[j] <= w_ahi * $signed({1'b0, w_blo});
                r2_hh[j] <= w_ahi * w_bhi;
            end
        end

        // sum mod 2^P; the true product fits in P signed bits
        assign w_sum = (P'(r2_hh[j]) << (2 * K))
                     + ((P'(r2_lh[j]) + P'(r2_hl[j])) << K)
                     + P'(r2_ll[j]);

        always_ff @(posedge i_clk) begin
            if (i_en.s3) begin
                r3_prod[j] <= $signed(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_span  <= r1_span;
            r2_vert  <= r1_vert;
            r2_dypos <= r1_dypos;
        end
        if (i_en.s3) begin
            r3_span  <= r2_span;
            r3_vert  <= r2_vert;
            r3_dypos <= r2_dypos;
        end
    end

    // compare sense flips with the sign of dy
    logic w_le;

    assign w_le    = r3_dypos ? (r3_prod[0] <= r3_prod[1]) : (r3_prod[1] <= r3_prod[0]);
    assign o_cross = r3_span && (r3_vert || w_le);

endmodule

`default_nettype wire

[rtl/core/point_in_triangle_ray_cast.sv]
// Channel    | Dir | Payload                  | Notes
// -----------+-----+--------------------------+------------------------------
// i_pt       | in  | point_l, point_m         | one point per word
// o_res      | out | inside_res               | one result per point, in order
// i_cfg      | in  | index, value             | vertex writes, ready out of reset
//
// One point per cycle sustained while the output is taken; a taken point passes
// through edge stage 1 diffs, stage 2 partial products, stage 3 sums and the
// output reg before its result is valid. The 2x2 split of each cross product over
// two stages sets that depth.
// Reset clears the valid bits and the vertex registers to zero; no word is taken
// while reset is held.
// Each stage holds its word while the next one is full and stalled, so input
// ready drops only when every stage is occupied and the output is not taken.
//
// Top level of the point-in-triangle test; uses pitrc_pkg, pitrc_chan_if,
// pitrc_edge and the assertion macro header.
`default_nettype none
`include "point_in_triangle_ray_cast_assert.svh"

module point_in_triangle_ray_cast #(
    parameter int COORD_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pitrc_chan_if.sink   i_pt,
    pitrc_chan_if.source o_res,
    pitrc_chan_if.sink   i_cfg
);

    localparam int FB = pitrc_pkg::FIELD_BITS;

    // vertex registers
    logic [FB-1:0] r_vtx [pitrc_pkg::NUM_REGS];

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pitrc_pkg::NUM_REGS; k++) begin
                r_vtx[k] <= '0;
            end
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                pitrc_pkg::REG_A_L: r_vtx[pitrc_pkg::REG_A_L] <= i_cfg.data.value;
                pitrc_pkg::REG_A_M: r_vtx[pitrc_pkg::REG_A_M] <= i_cfg.data.value;
                pitrc_pkg::REG_B_L: r_vtx[pitrc_pkg::REG_B_L] <= i_cfg.data.value;
                pitrc_pkg::REG_B_M: r_vtx[pitrc_pkg::REG_B_M] <= i_cfg.data.value;
                pitrc_pkg::REG_C_L: r_vtx[pitrc_pkg::REG_C_L] <= i_cfg.data.value;
                pitrc_pkg::REG_C_M: r_vtx[pitrc_pkg::REG_C_M] <= i_cfg.data.value;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // coordinates: vertices 0..5, point 6..7, read within COORD_BITS
    logic [FB-1:0]               w_raw [8];
    logic signed [COORD_BITS-1:0] w_crd [8];

    for (genvar g = 0; g < pitrc_pkg::NUM_REGS; g++) begin : g_raw
        assign w_raw[g] = r_vtx[g];
    end
    assign w_raw[6] = i_pt.data.point_l;
    assign w_raw[7] = i_pt.data.point_m;

    for (genvar g = 0; g < 8; g++) begin : g_crd
        if (COORD_BITS <= FB) begin : g_trunc
            assign w_crd[g] = $signed(w_raw[g][COORD_BITS-1:0]);
        end else begin : g_zext
            // bits of a wide coordinate above FB are never set by a 32-bit word; they are zero
            assign w_crd[g] = $signed({{(COORD_BITS-FB){1'b0}}, w_raw[g]});
        end
    end

    // pipeline control
    logic                 r_v1, r_v2, r_v3;
    logic                 w_en4;
    pitrc_pkg::t_stage_en w_en;

    assign w_en4     = !o_res.valid || o_res.ready;
    assign w_en.s3   = !r_v3 || w_en4;
    assign w_en.s2   = !r_v2 || w_en.s3;
    assign w_en.s1   = !r_v1 || w_en.s2;
    assign i_pt.ready = w_en.s1 && i_rst_n;

    logic r_out_v;
    logic r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en.s1) r_v1    <= i_pt.valid;
            if (w_en.s2) r_v2    <= r_v1;
            if (w_en.s3) r_v3    <= r_v2;
            if (w_en4)   r_out_v <= r_v3;
        end
    end

    // edge BC lying flat at the point's y adds one crossing
    logic w_bc_flat;
    logic r_bc1, r_bc2, r_bc3;

    assign w_bc_flat = (w_crd[pitrc_pkg::REG_B_M] == w_crd[pitrc_pkg::REG_C_M])
                    && (w_crd[7] == w_crd[pitrc_pkg::REG_B_M]);

    always_ff @(posedge i_clk) begin
        if (w_en.s1) r_bc1 <= w_bc_flat;
        if (w_en.s2) r_bc2 <= r_bc1;
        if (w_en.s3) r_bc3 <= r_bc2;
    end

    logic w_cross_ab, w_cross_bc, w_cross_ca;

    pitrc_edge #(.CB(COORD_BITS)) u_edge_ab (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (w_crd[pitrc_pkg::REG_A_L]),
        .i_py    (w_crd[pitrc_pkg::REG_A_M]),
        .i_qx    (w_crd[pitrc_pkg::REG_B_L]),
        .i_qy    (w_crd[pitrc_pkg::REG_B_M]),
        .i_x     (w_crd[6]),
        .i_y     (w_crd[7]),
        .o_cross (w_cross_ab)
    );

    pitrc_edge #(.CB(COORD_BITS)) u_edge_bc (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (w_crd[pitrc_pkg::REG_B_L]),
        .i_py    (w_crd[pitrc_pkg::REG_B_M]),
        .i_qx    (w_crd[pitrc_pkg::REG_C_L]),
        .i_qy    (w_crd[pitrc_pkg::REG_C_M]),
        .i_x     (w_crd[6]),
        .i_y     (w_crd[7]),
        .o_cross (w_cross_bc)
    );

    pitrc_edge #(.CB(COORD_BITS)) u_edge_ca (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (w_crd[pitrc_pkg::REG_C_L]),
        .i_py    (w_crd[pitrc_pkg::REG_C_M]),
        .i_qx    (w_crd[pitrc_pkg::REG_A_L]),
        .i_qy    (w_crd[pitrc_pkg::REG_A_M]),
        .i_x     (w_crd[6]),
        .i_y     (w_crd[7]),
        .o_cross (w_cross_ca)
    );

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_inside <= w_cross_ab ^ w_cross_bc ^ w_cross_ca ^ r_bc3;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.data.inside_res = r_inside;

    // a taken point always lands in stage 1
    `PITRC_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_v1)
    // a stalled last stage keeps its word and the output stays valid
    `PITRC_ASSERT_NXT(a_s3_holds, i_clk, i_rst_n, r_v3 && !w_en.s3, r_v3 && o_res.valid)
    // input backpressure only when every stage is full behind a stalled output
    `PITRC_ASSERT_IMP(a_ready_low, i_clk, i_rst_n, !i_pt.ready,
                      r_v1 && r_v2 && r_v3 && o_res.valid && !o_res.ready)

endmodule

`default_nettype wire
